### rtl/sqlgd_pkg.sv
// ----------------------------------------------------------------------------
// sqlgd_pkg
// shared constants and types of the server greeting signature detector
// ----------------------------------------------------------------------------
package sqlgd_pkg;

    localparam int unsigned OFFSET_BITS = 16;
    localparam int unsigned LEN_BITS    = 16;
    localparam int unsigned BYTE_BITS   = 8;

    localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};

    // header offsets
    localparam logic [OFFSET_BITS-1:0] HDR_LEN_LO = OFFSET_BITS'(0);
    localparam logic [OFFSET_BITS-1:0] HDR_LEN_HI = OFFSET_BITS'(1);
    localparam logic [OFFSET_BITS-1:0] HDR_ZERO_A = OFFSET_BITS'(2);
    localparam logic [OFFSET_BITS-1:0] HDR_ZERO_B = OFFSET_BITS'(3);
    localparam logic [OFFSET_BITS-1:0] HDR_VER    = OFFSET_BITS'(5);
    localparam logic [OFFSET_BITS-1:0] HDR_DOT    = OFFSET_BITS'(6);
    localparam logic [OFFSET_BITS-1:0] NUL_MIN    = OFFSET_BITS'(7);

    localparam logic [LEN_BITS-1:0]  MIN_LEN  = LEN_BITS'(37);
    localparam logic [LEN_BITS-1:0]  LEN_BIAS = LEN_BITS'(4);
    localparam logic [BYTE_BITS-1:0] VER_LOW  = 8'h30;
    localparam logic [BYTE_BITS-1:0] VER_HIGH = 8'h37;
    localparam logic [BYTE_BITS-1:0] DOT_CHAR = 8'h2e;

    // filler positions relative to the zero byte
    localparam logic [OFFSET_BITS-1:0] FILL_A   = OFFSET_BITS'(13);
    localparam logic [OFFSET_BITS-1:0] FILL_B   = OFFSET_BITS'(19);
    localparam logic [OFFSET_BITS-1:0] FILL_END = OFFSET_BITS'(31);

    typedef struct packed {
        logic [OFFSET_BITS-1:0] byte_offset;
        logic [BYTE_BITS-1:0]   header_length_low;
        logic                   header_good;
        logic                   nul_seen;
        logic [OFFSET_BITS-1:0] nul_position;
        logic                   filler_good;
    } t_state;

    localparam t_state STATE_RESET = '{
        byte_offset:       '0,
        header_length_low: '0,
        header_good:       1'b1,
        nul_seen:          1'b0,
        nul_position:      '0,
        filler_good:       1'b1
    };

endpackage

### rtl/sqlgd_inspect.sv
// ----------------------------------------------------------------------------
// sqlgd_inspect
// per-byte signature checks: next running state and the end-of-payload verdict
// ----------------------------------------------------------------------------
module sqlgd_inspect import sqlgd_pkg::*; (
    input  t_state               i_state,
    input  logic [BYTE_BITS-1:0] i_payload_byte,
    input  logic [LEN_BITS-1:0]  i_payload_length,
    input  logic                 i_last_byte,
    output t_state               o_state,
    output logic                 o_verdict
);

    t_state                 w_upd;
    logic [OFFSET_BITS-1:0] w_off;
    logic [OFFSET_BITS-1:0] w_rel;
    logic [OFFSET_BITS:0]   w_off_end;
    logic [OFFSET_BITS:0]   w_nul_end;
    logic [BYTE_BITS-1:0]   w_b;
    logic                   w_b_zero;
    logic                   w_fill_pos;

    assign w_off     = i_state.byte_offset;
    assign w_b       = i_payload_byte;
    assign w_b_zero  = (w_b == '0);
    assign w_rel     = w_off - i_state.nul_position;
    assign w_off_end = {1'b0, w_off} + {1'b0, FILL_END};
    assign w_fill_pos = (w_rel == FILL_A) || ((w_rel >= FILL_B) && (w_rel <= FILL_END));

    always_comb begin
        w_upd = i_state;
        if (w_off != OFF_MAX) begin
            unique case (w_off)
                HDR_LEN_LO: begin
                    w_upd.header_length_low = w_b;
                end
                HDR_LEN_HI: begin
                    if ((i_payload_length < LEN_BIAS) ||
                        ({w_b, i_state.header_length_low} != (i_payload_length - LEN_BIAS)))
                        w_upd.header_good = 1'b0;
                end
                HDR_ZERO_A, HDR_ZERO_B: begin
                    if (!w_b_zero) w_upd.header_good = 1'b0;
                end
                HDR_VER: begin
                    if (!((w_b > VER_LOW) && (w_b < VER_HIGH))) w_upd.header_good = 1'b0;
                end
                HDR_DOT: begin
                    if (w_b != DOT_CHAR) w_upd.header_good = 1'b0;
                end
                default: begin
                end
            endcase
            if (i_state.nul_seen) begin
                if ((w_off > i_state.nul_position) && w_fill_pos && !w_b_zero)
                    w_upd.filler_good = 1'b0;
            end else if ((w_off >= NUL_MIN) && (w_off_end < {1'b0, i_payload_length})
                         && w_b_zero) begin
                w_upd.nul_seen     = 1'b1;
                w_upd.nul_position = w_off;
            end
        end
    end

    assign w_nul_end = {1'b0, w_upd.nul_position} + {1'b0, FILL_END};

    assign o_verdict = (i_payload_length > MIN_LEN) && w_upd.header_good
                       && w_upd.nul_seen && w_upd.filler_good
                       && (w_nul_end < {1'b0, OFF_MAX})
                       && ({1'b0, w_off} >= w_nul_end);

    always_comb begin
        o_state = w_upd;
        if (i_last_byte) begin
            o_state = STATE_RESET;
        end else if (w_off != OFF_MAX) begin
            o_state.byte_offset = w_off + OFFSET_BITS'(1);
        end
    end

endmodule

### rtl/sql_server_greeting_detector.sv
// ----------------------------------------------------------------------------
// sql_server_greeting_detector
// streaming check of a tcp payload for the database server greeting signature
// ----------------------------------------------------------------------------
// The block takes one payload byte per beat, with the payload length and a
// last-byte mark, and gives one verdict beat per payload, on its last byte:
// 1 when the greeting matched, 0 when the protocol is excluded. Checks are the
// little-endian length at offsets 0..1 equal to length minus 4, zero bytes at
// 2 and 3, a version digit 0x31..0x36 at 5, a dot at 6, a length above 37,
// then the first zero byte p at offset 7 or more (with p+31 below the length)
// followed by zero filler at p+13 and p+19..p+31. Rate is one byte per clock
// while no last byte waits on an untaken verdict: the per-byte work is a
// handful of compares against the running offset, done in one pass between
// the input register and the verdict register. The input side keeps taking
// bytes while a verdict waits; only a last byte stalls behind an untaken
// verdict. After the last byte the running state is back at reset, ready for
// the next payload. The byte offset saturates at 2^16-1; bytes at that offset
// are not inspected.
// ----------------------------------------------------------------------------
module sql_server_greeting_detector import sqlgd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [BYTE_BITS-1:0] i_payload_byte,
    input  logic [LEN_BITS-1:0]  i_payload_length,
    input  logic                 i_last_byte,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_verdict
);

    // input register
    logic                 r_in_valid;
    logic [BYTE_BITS-1:0] r_in_byte;
    logic [LEN_BITS-1:0]  r_in_len;
    logic                 r_in_last;

    // running state of the current payload
    t_state r_state;
    t_state n_state;

    // verdict register
    logic r_out_valid;
    logic r_verdict;
    logic n_verdict;

    logic w_out_free;
    logic w_fire;

    // the verdict slot is free when empty or being taken this cycle
    assign w_out_free = !r_out_valid || i_out_ready;
    // a middle byte never needs the verdict slot
    assign w_fire     = r_in_valid && (!r_in_last || w_out_free);
    assign o_in_ready = !r_in_valid || w_fire;

    sqlgd_inspect u_inspect (
        .i_state          (r_state),
        .i_payload_byte   (r_in_byte),
        .i_payload_length (r_in_len),
        .i_last_byte      (r_in_last),
        .o_state          (n_state),
        .o_verdict        (n_verdict)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // payload of the input register
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_payload_byte;
            r_in_len  <= i_payload_length;
            r_in_last <= i_last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (w_fire) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && r_in_last) begin
            r_verdict <= n_verdict;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_verdict   = r_verdict;

    // a last byte leaves the state at reset for the next payload
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_in_last) |=> (r_state == STATE_RESET))
        else $error("state not cleared after last byte");

    // a middle byte always moves the offset off zero
    a_offset_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && !r_in_last) |=> (r_state.byte_offset != '0))
        else $error("offset did not advance");

    // the zero byte is never taken inside the fixed header
    a_nul_past_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.nul_seen |-> (r_state.nul_position >= NUL_MIN))
        else $error("zero byte position inside header");

    // a pending verdict is never overwritten before it is taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !(w_fire && r_in_last))
        else $error("verdict overwritten");

endmodule

### tb/sqlgd_checker.sv
// ----------------------------------------------------------------------------
// sqlgd_checker
// watches both channels of the greeting detector, predicts each verdict and
// compares it with the verdict beat that the block gives
// ----------------------------------------------------------------------------
module sqlgd_checker import sqlgd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic [BYTE_BITS-1:0] i_payload_byte,
    input  logic [LEN_BITS-1:0]  i_payload_length,
    input  logic                 i_last_byte,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic                 i_verdict,
    output int                   o_pending,
    output int                   o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // running scan of the current payload
    logic [OFFSET_BITS-1:0] scan_offset;
    logic [BYTE_BITS-1:0]   len_low_byte;
    logic                   header_ok;
    logic                   zero_found;
    logic [OFFSET_BITS-1:0] zero_offset;
    logic                   filler_ok;

    bit expected_verdicts[$];
    bit wanted_verdict;
    int mismatches = 0;

    task automatic clear_scan();
        scan_offset  = '0;
        len_low_byte = '0;
        header_ok    = 1'b1;
        zero_found   = 1'b0;
        zero_offset  = '0;
        filler_ok    = 1'b1;
    endtask

    // fold one payload byte into the scan, queue a verdict on the last byte
    task automatic scan_byte(input logic [BYTE_BITS-1:0] b, input logic [LEN_BITS-1:0] len,
                             input logic last);
        int unsigned here;
        int unsigned gap;
        int unsigned zpos;
        bit          hit;
        here = scan_offset;
        if (here < OFF_MAX) begin
            case (scan_offset)
                HDR_LEN_LO: len_low_byte = b;
                HDR_LEN_HI: begin
                    if (len < LEN_BIAS || {b, len_low_byte} != len - LEN_BIAS)
                        header_ok = 1'b0;
                end
                HDR_ZERO_A, HDR_ZERO_B: begin
                    if (b != '0)
                        header_ok = 1'b0;
                end
                HDR_VER: begin
                    if (!(b > VER_LOW && b < VER_HIGH))
                        header_ok = 1'b0;
                end
                HDR_DOT: begin
                    if (b != DOT_CHAR)
                        header_ok = 1'b0;
                end
                default: ;
            endcase
            if (zero_found) begin
                if (here > zero_offset) begin
                    gap = here - zero_offset;
                    if ((gap == FILL_A || (gap >= FILL_B && gap <= FILL_END)) && b != '0)
                        filler_ok = 1'b0;
                end
            end else if (here >= NUL_MIN && here + FILL_END < len && b == '0) begin
                zero_found  = 1'b1;
                zero_offset = scan_offset;
            end
        end
        if (!last) begin
            if (scan_offset < OFF_MAX)
                scan_offset = scan_offset + 1'b1;
        end else begin
            zpos = zero_offset;
            hit  = len > MIN_LEN && header_ok && zero_found && filler_ok
                   && zpos + FILL_END < OFF_MAX && here >= zpos + FILL_END;
            expected_verdicts.push_back(hit);
            clear_scan();
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_scan();
            expected_verdicts.delete();
        end else begin
            // verdict first: it can never belong to a byte taken at this edge
            if (i_out_valid && i_out_ready) begin
                if (expected_verdicts.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: verdict beat with none pending, expected none, got %0b",
                             $time, i_verdict);
                end else begin
                    wanted_verdict = expected_verdicts.pop_front();
                    if (i_verdict !== wanted_verdict) begin
                        mismatches++;
                        $display("%0t ns: verdict mismatch, expected %0b, got %0b",
                                 $time, wanted_verdict, i_verdict);
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                scan_byte(i_payload_byte, i_payload_length, i_last_byte);
        end
        o_pending    <= expected_verdicts.size();
        o_fail_count <= mismatches;
    end

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the server greeting signature detector
// ----------------------------------------------------------------------------
// Feeds payloads one byte per beat: a few directed payloads (minimum greeting,
// version digit edges, cut-short payload, bytes past the length, a length that
// changes on the last byte), then mostly well-formed greetings with random
// content and maybe one flaw, mixed with short and noise payloads. Both sides
// idle at random. A separate checker predicts and compares every verdict beat.
// ----------------------------------------------------------------------------
module tb import sqlgd_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RAND_BEATS      = 1175;  // random payload bytes to send
    localparam int MIN_RAND_VERDS  = 12;    // random payloads, each gives one verdict
    localparam int CALM_FROM       = 400;   // random beats with no idling on either side
    localparam int CALM_TO         = 900;
    localparam int TAIL_CYCLES     = 16;    // settle time after the last verdict
    localparam int WATCHDOG_LIMIT  = 2000;  // cycles with no beat on either channel

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    logic [BYTE_BITS-1:0] pay_byte  = '0;
    logic [LEN_BITS-1:0]  pay_len   = '0;
    logic                 pay_last  = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 verdict;

    int pending;
    int fail_count;

    // no-idle window, registered so both sides see the same value
    logic calm = 1'b0;

    int beats_sent   = 0;
    int rand_packets = 0;
    int quiet_cycles = 0;

    // payload under construction: one byte and one length per beat
    logic [BYTE_BITS-1:0] pkt_bytes[$];
    logic [LEN_BITS-1:0]  pkt_lens[$];

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    sql_server_greeting_detector DUT (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_payload_byte   (pay_byte),
        .i_payload_length (pay_len),
        .i_last_byte      (pay_last),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_verdict        (verdict)
    );

    sqlgd_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_payload_byte   (pay_byte),
        .i_payload_length (pay_len),
        .i_last_byte      (pay_last),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_verdict        (verdict),
        .o_pending        (pending),
        .o_fail_count     (fail_count)
    );

    // verdict side: stall with a chance of about 6 percent, never in the calm window
    always @(posedge clk) begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= calm || ($urandom_range(99) >= 6);
    end

    // watchdog: a stretch with no beat on either side means the block hung
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // one byte beat; returns at the edge where it is taken
    task automatic send_beat(input logic [BYTE_BITS-1:0] b, input logic [LEN_BITS-1:0] len,
                             input logic last);
        calm <= (beats_sent >= CALM_FROM && beats_sent < CALM_TO);
        // random gap before the beat
        while (!calm && $urandom_range(99) < 6) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pay_byte <= b;
        pay_len  <= len;
        pay_last <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        beats_sent++;
    endtask

    task automatic send_packet();
        for (int k = 0; k < pkt_bytes.size(); k++)
            send_beat(pkt_bytes[k], pkt_lens[k], k == pkt_bytes.size() - 1);
    endtask

    // hold the sender until every verdict owed has come out
    task automatic drain_verdicts();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // well-formed greeting: header, nonzero run up to the zero byte, zero filler
    task automatic make_greeting(input int unsigned plen, input int unsigned nul_at,
                                 input logic [BYTE_BITS-1:0] ver);
        int unsigned gap;
        logic [BYTE_BITS-1:0] b;
        pkt_bytes.delete();
        pkt_lens.delete();
        for (int unsigned k = 0; k < plen; k++) begin
            b = 8'($urandom);
            if (k == HDR_LEN_LO)
                b = 8'(plen - LEN_BIAS);
            else if (k == HDR_LEN_HI)
                b = 8'((plen - LEN_BIAS) >> 8);
            else if (k == HDR_ZERO_A || k == HDR_ZERO_B)
                b = '0;
            else if (k == HDR_VER)
                b = ver;
            else if (k == HDR_DOT)
                b = DOT_CHAR;
            else if (k >= NUL_MIN && k < nul_at)
                b = 8'($urandom_range(1, 255));
            else if (k == nul_at)
                b = '0;
            else if (k > nul_at) begin
                gap = k - nul_at;
                if (gap == FILL_A || (gap >= FILL_B && gap <= FILL_END))
                    b = '0;
            end
            pkt_bytes.push_back(b);
            pkt_lens.push_back(16'(plen));
        end
    endtask

    // cut the payload short after keep bytes
    task automatic trim_packet(input int unsigned keep);
        while (pkt_bytes.size() > keep) begin
            void'(pkt_bytes.pop_back());
            void'(pkt_lens.pop_back());
        end
    endtask

    // append bytes past the stated length, some of them zero
    task automatic pad_packet(input int unsigned extra);
        repeat (extra) begin
            pkt_bytes.push_back(($urandom_range(3) == 0) ? 8'h00 : 8'($urandom));
            pkt_lens.push_back(pkt_lens[pkt_lens.size() - 1]);
        end
    endtask

    logic [BYTE_BITS-1:0] ver_edges[4];

    initial begin
        int unsigned plen;
        int unsigned nul_at;
        int unsigned n;
        int unsigned from;
        logic [LEN_BITS-1:0]  nlen;
        logic [BYTE_BITS-1:0] b;

        ver_edges[0] = VER_LOW;
        ver_edges[1] = VER_LOW + 1'b1;
        ver_edges[2] = VER_HIGH - 1'b1;
        ver_edges[3] = VER_HIGH;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---------------- directed part ----------------
        // one-byte payloads at the extremes of byte and length
        pkt_bytes = '{8'hff};
        pkt_lens  = '{16'hffff};
        send_packet();
        pkt_bytes = '{8'h00};
        pkt_lens  = '{16'h0000};
        send_packet();

        // shortest greeting that can match, then the version digit edges
        make_greeting(39, 7, 8'h33);
        send_packet();
        foreach (ver_edges[i]) begin
            make_greeting(39, 7, ver_edges[i]);
            send_packet();
        end

        // short payload: last byte one short of the filler end, then just at it
        make_greeting(60, 10, 8'h35);
        trim_packet(10 + 31);
        send_packet();
        make_greeting(60, 10, 8'h35);
        trim_packet(10 + 32);
        send_packet();

        // bytes past the stated length
        make_greeting(40, 8, 8'h31);
        pad_packet(10);
        send_packet();

        // length changes on the final byte
        make_greeting(45, 9, 8'h36);
        pkt_lens[pkt_lens.size() - 1] = 16'd30;
        send_packet();

        // sender waits out every verdict at least once
        drain_verdicts();

        // ---------------- random part ----------------
        beats_sent = 0;
        while (beats_sent < RAND_BEATS || rand_packets < MIN_RAND_VERDS) begin
            n = $urandom_range(99);
            if (n < 15) begin
                // noise: a few random bytes with a random length
                n    = $urandom_range(1, 12);
                nlen = 16'($urandom);
                pkt_bytes.delete();
                pkt_lens.delete();
                repeat (n) begin
                    pkt_bytes.push_back(8'($urandom));
                    pkt_lens.push_back(($urandom_range(3) == 0) ? 16'($urandom) : nlen);
                end
            end else if (n < 23) begin
                // greeting-like payload shorter than any greeting that can match
                plen = $urandom_range(0, 38);
                n    = (plen == 0) ? 1 : plen;
                pkt_bytes.delete();
                pkt_lens.delete();
                for (int unsigned k = 0; k < n; k++) begin
                    b = 8'($urandom);
                    if (k == HDR_LEN_LO)
                        b = 8'(plen - LEN_BIAS);
                    else if (k == HDR_LEN_HI)
                        b = 8'((plen - LEN_BIAS) >> 8);
                    else if (k == HDR_ZERO_A || k == HDR_ZERO_B)
                        b = '0;
                    else if (k == HDR_VER)
                        b = 8'h33;
                    else if (k == HDR_DOT)
                        b = DOT_CHAR;
                    else if (k > HDR_DOT && $urandom_range(3) == 0)
                        b = '0;
                    pkt_bytes.push_back(b);
                    pkt_lens.push_back(16'(plen));
                end
            end else begin
                // well-formed greeting with random content, then maybe one flaw
                plen   = ($urandom_range(9) == 0) ? $urandom_range(81, 300)
                                                  : $urandom_range(39, 80);
                nul_at = ($urandom_range(2) == 0) ? plen - 32 : $urandom_range(NUL_MIN, plen - 32);
                make_greeting(plen, nul_at, 8'($urandom_range(VER_LOW + 1, VER_HIGH - 1)));
                case ($urandom_range(11))
                    4: pkt_bytes[$urandom_range(plen - 1)] = 8'($urandom);
                    5: begin
                        if ($urandom_range(1) == 0)
                            pkt_bytes[HDR_VER] = ver_edges[$urandom_range(3)];
                        else
                            pkt_bytes[$urandom_range(HDR_DOT)] ^= 8'($urandom_range(1, 255));
                    end
                    6: begin
                        if ($urandom_range(1) == 0)
                            trim_packet($urandom_range(nul_at + 30, nul_at + 32));
                        else
                            trim_packet($urandom_range(1, plen - 1));
                    end
                    7: pad_packet($urandom_range(1, 40));
                    8: begin
                        // one filler byte made nonzero
                        n = ($urandom_range(3) == 0) ? FILL_A : $urandom_range(FILL_B, FILL_END);
                        pkt_bytes[nul_at + n] = 8'($urandom_range(1, 255));
                    end
                    9: begin
                        // earlier zero byte moves the terminator
                        if (nul_at > NUL_MIN)
                            pkt_bytes[$urandom_range(NUL_MIN, nul_at - 1)] = '0;
                    end
                    10: begin
                        // length changes from some byte on
                        from = $urandom_range(plen - 1);
                        nlen = ($urandom_range(1) == 0) ? 16'($urandom)
                                                        : 16'(plen + $urandom_range(2) - 1);
                        for (int unsigned k = from; k < pkt_lens.size(); k++)
                            pkt_lens[k] = nlen;
                    end
                    default: ;
                endcase
            end
            send_packet();
            rand_packets++;
            if ($urandom_range(15) == 0)
                drain_verdicts();
        end

        // ---------------- wind down ----------------
        drain_verdicts();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
